[hw/rtl/psflm_pkg.sv]
// ----------------------------------------------------------------------------
// psflm_pkg: shared types for the per-source flit latency monitor
// Request payload types for the flit and result channels, register indexes
// and field widths.
// ----------------------------------------------------------------------------
package psflm_pkg;

  // field widths
  localparam int unsigned CYCLE_W   = 32;
  localparam int unsigned SRC_W     = 4;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned SEEN_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARM_UP      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_OFFSET = 1'b1;

  // sources_seen stops here
  localparam logic [SEEN_W-1:0] SEEN_TOP = 5'd31;

  // one arriving flit
  typedef struct packed {
    logic [CYCLE_W-1:0] arrival_cycle;
    logic [SRC_W-1:0]   source_node;
    logic               is_head;
    logic [CYCLE_W-1:0] inject_cycle;
  } in_flit_t;

  // statistics returned for one flit
  typedef struct packed {
    logic               accepted;
    logic               first_from_source;
    logic [SRC_W-1:0]   source_echo;
    logic [CYCLE_W-1:0] source_flits;
    logic [CYCLE_W-1:0] source_packets;
    logic [SUM_W-1:0]   source_delay_sum;
    logic [CYCLE_W-1:0] source_max_delay;
    logic [CYCLE_W-1:0] source_last_time;
    logic [SEEN_W-1:0]  sources_seen;
    logic [CYCLE_W-1:0] all_flits;
    logic [CYCLE_W-1:0] all_packets;
  } out_stats_t;

endpackage

[hw/rtl/per_source_flit_latency_monitor_top.sv]
// ----------------------------------------------------------------------------
// per_source_flit_latency_monitor_top: per-source flit latency monitor
// Counts flits, head packets and head-flit delays per source node after a
// warm-up window, keeps global totals, and returns one result per flit.
// ----------------------------------------------------------------------------
// path: a taken flit waits in the input register, its result in the result
//   register; throughput: one flit per cycle while out_ready takes each result;
//   the per-source read-modify-write is done in one pass between these registers
// reset: synchronous active-low; entry valid bits and totals clear with no
//   clearing pass; entries read as zero until first written
module per_source_flit_latency_monitor_top #(
  parameter int unsigned NODES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // flit channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psflm_pkg::in_flit_t                 in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output psflm_pkg::out_stats_t               out_data,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [psflm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psflm_pkg::CFG_DAT_W-1:0]     cfg_wr_data
);

  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW    = psflm_pkg::CYCLE_W;
  localparam int unsigned SW    = psflm_pkg::SUM_W;
  localparam int unsigned NW    = psflm_pkg::SEEN_W;
  localparam logic [CW-1:0] CNT_TOP = {CW{1'b1}};
  localparam logic [SW-1:0] SUM_TOP = {SW{1'b1}};

  // configuration registers
  logic [CW-1:0] warm_up_r;
  logic [CW-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_up_r <= '0;
      offset_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psflm_pkg::CFG_WARM_UP:      warm_up_r <= cfg_wr_data[CW-1:0];
        psflm_pkg::CFG_RESET_OFFSET: offset_r  <= cfg_wr_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic                 in_v_r;
  psflm_pkg::in_flit_t  in_q_r;
  logic                 out_v_r;
  psflm_pkg::out_stats_t out_q_r;
  logic                 proc_go;

  assign proc_go  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
  end

  // per-source store and totals
  logic [NODES-1:0]         vld_r;
  logic [CW-1:0]            flits_r   [NODES];
  logic [CW-1:0]            packets_r [NODES];
  logic [SW-1:0]            dsum_r    [NODES];
  logic [CW-1:0]            dmax_r    [NODES];
  logic [CW-1:0]            last_r    [NODES];
  logic [psflm_pkg::SEEN_W-1:0] seen_r;
  logic [CW-1:0]            all_flits_r;
  logic [CW-1:0]            all_packets_r;

  // read current entry of the flit's source
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             cur_vld;
  logic [CW-1:0]    cur_flits, cur_packets, cur_dmax, cur_last;
  logic [SW-1:0]    cur_dsum;

  assign idx      = IDX_W'(in_q_r.source_node);
  assign in_range = (32'(in_q_r.source_node) < 32'(NODES));
  assign cur_vld  = vld_r[idx];

  always_comb begin
    cur_flits   = cur_vld ? flits_r[idx]   : '0;
    cur_packets = cur_vld ? packets_r[idx] : '0;
    cur_dsum    = cur_vld ? dsum_r[idx]    : '0;
    cur_dmax    = cur_vld ? dmax_r[idx]    : '0;
    cur_last    = cur_vld ? last_r[idx]    : '0;
  end

  // warm-up test, delay and saturating updates
  logic          accept;
  logic          first;
  logic          head_hit;
  logic [CW-1:0] since_off;
  logic [CW-1:0] delay;
  logic [SW:0]   sum_wide;
  logic [CW-1:0] flits_nxt, packets_nxt, dmax_nxt, last_nxt;
  logic [SW-1:0] dsum_nxt;
  logic [psflm_pkg::SEEN_W-1:0] seen_nxt;
  logic [CW-1:0] all_flits_nxt, all_packets_nxt;

  always_comb begin
    since_off = in_q_r.arrival_cycle - offset_r;
    accept    = in_range && (in_q_r.arrival_cycle >= offset_r) && (since_off >= warm_up_r);
    first     = accept && !cur_vld;
    head_hit  = accept && in_q_r.is_head;
    delay     = (in_q_r.arrival_cycle > in_q_r.inject_cycle) ?
                (in_q_r.arrival_cycle - in_q_r.inject_cycle) : '0;
    sum_wide  = {1'b0, cur_dsum} + (SW+1)'(delay);

    flits_nxt   = cur_flits;
    packets_nxt = cur_packets;
    dsum_nxt    = cur_dsum;
    dmax_nxt    = cur_dmax;
    last_nxt    = cur_last;
    if (accept) begin
      flits_nxt = (cur_flits == CNT_TOP) ? CNT_TOP : cur_flits + CW'(1);
      last_nxt  = in_q_r.arrival_cycle - warm_up_r;
    end
    if (head_hit) begin
      packets_nxt = (cur_packets == CNT_TOP) ? CNT_TOP : cur_packets + CW'(1);
      dsum_nxt    = sum_wide[SW] ? SUM_TOP : sum_wide[SW-1:0];
      dmax_nxt    = (delay > cur_dmax) ? delay : cur_dmax;
    end

    seen_nxt = seen_r;
    if (first && seen_r != psflm_pkg::SEEN_TOP) begin
      seen_nxt = seen_r + NW'(1);
    end
    all_flits_nxt = all_flits_r;
    if (accept && all_flits_r != CNT_TOP) begin
      all_flits_nxt = all_flits_r + CW'(1);
    end
    all_packets_nxt = all_packets_r;
    if (head_hit && all_packets_r != CNT_TOP) begin
      all_packets_nxt = all_packets_r + CW'(1);
    end
  end

  // store write-back: valid bits and totals reset, entry data does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= '0;
      seen_r        <= '0;
      all_flits_r   <= '0;
      all_packets_r <= '0;
    end else if (proc_go) begin
      if (accept) begin
        vld_r[idx] <= 1'b1;
      end
      seen_r        <= seen_nxt;
      all_flits_r   <= all_flits_nxt;
      all_packets_r <= all_packets_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && accept) begin
      flits_r[idx]   <= flits_nxt;
      packets_r[idx] <= packets_nxt;
      dsum_r[idx]    <= dsum_nxt;
      dmax_r[idx]    <= dmax_nxt;
      last_r[idx]    <= last_nxt;
    end
  end

  // result register
  psflm_pkg::out_stats_t res_nxt;

  always_comb begin
    res_nxt.accepted          = accept;
    res_nxt.first_from_source = first;
    res_nxt.source_echo       = in_q_r.source_node;
    res_nxt.source_flits      = in_range ? flits_nxt   : '0;
    res_nxt.source_packets    = in_range ? packets_nxt : '0;
    res_nxt.source_delay_sum  = in_range ? dsum_nxt    : '0;
    res_nxt.source_max_delay  = in_range ? dmax_nxt    : '0;
    res_nxt.source_last_time  = in_range ? last_nxt    : '0;
    res_nxt.sources_seen      = seen_nxt;
    res_nxt.all_flits         = all_flits_nxt;
    res_nxt.all_packets       = all_packets_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      out_q_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_q_r;

  // checks on the monitor's own bookkeeping
  a_first_is_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_q_r.first_from_source |-> out_q_r.accepted)
    else $error("first_from_source without accepted");

  a_first_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_q_r.first_from_source |-> out_q_r.source_flits == 32'd1)
    else $error("new source entry does not hold one flit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled with room downstream");

  a_seen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) |-> seen_r >= $past(seen_r))
    else $error("sources seen count went down");

endmodule
